### rtl/ivfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfd_pkg: shared types and constants for the IVF stream deframer
// Parse modes, byte classes, header layout constants and the result record.
// ----------------------------------------------------------------------------
package ivfd_pkg;

  // File header layout
  localparam logic [31:0] IVF_MAGIC      = 32'h46494b44;
  localparam logic [15:0] FILE_HDR_LEN   = 16'd32;
  localparam logic [5:0]  FILE_HDR_LAST  = 6'd31;
  localparam logic [5:0]  FRAME_HDR_LAST = 6'd11;
  localparam logic [5:0]  SIG_END        = 6'd4;
  localparam logic [5:0]  VL_END         = 6'd8;
  localparam logic [5:0]  COUNT_START    = 6'd24;
  localparam logic [5:0]  COUNT_END      = 6'd28;

  // Parser mode, encoded as the byte class it produces
  typedef enum logic [2:0] {
    MODE_FILE_HDR  = 3'd0,
    MODE_FRAME_HDR = 3'd1,
    MODE_PAYLOAD   = 3'd2,
    MODE_REJECTED  = 3'd3,
    MODE_PAST_END  = 3'd4
  } mode_t;

  // Byte classes on the output
  localparam logic [2:0] CLS_FILE_HDR  = 3'd0;
  localparam logic [2:0] CLS_FRAME_HDR = 3'd1;
  localparam logic [2:0] CLS_PAYLOAD   = 3'd2;
  localparam logic [2:0] CLS_REJECTED  = 3'd3;
  localparam logic [2:0] CLS_PAST_END  = 3'd4;

  // One result per input byte
  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  payload_byte;
    logic        header_accepted;
    logic        frame_header_done;
    logic [31:0] frame_size;
    logic [63:0] frame_timestamp;
    logic [31:0] frame_index;
    logic        frame_last;
  } res_t;

endpackage

### rtl/ivf_stream_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivf_stream_deframer: IVF container byte-stream deframer
// Classifies each IVF file byte and reports frame headers and payload.
// ----------------------------------------------------------------------------
// Takes one IVF file byte per transfer and returns one result per byte, in
// order. Throughput is one byte per clock while out_ready stays high. The
// input register holds the byte, then the parse logic writes the result
// into a two-entry output buffer, which drives out_valid. The 32-byte file
// header is checked for the DKIF signature, version 0 and header length
// 32; on failure every later byte is classed rejected. Frame size,
// timestamp and index appear on the last frame header byte and on every
// payload byte. After the frame count from the file header is reached,
// bytes are classed past end.
module ivf_stream_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_class,
  output logic [7:0]  payload_byte,
  output logic        header_accepted,
  output logic        frame_header_done,
  output logic [31:0] frame_size,
  output logic [63:0] frame_timestamp,
  output logic [31:0] frame_index,
  output logic        frame_last
);
  import ivfd_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_res;

  // Byte parser
  ivfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Result buffer
  ivfd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_ready (res_ready),
    .wr_data  (res),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_res)
  );

  assign byte_class        = out_res.byte_class;
  assign payload_byte      = out_res.payload_byte;
  assign header_accepted   = out_res.header_accepted;
  assign frame_header_done = out_res.frame_header_done;
  assign frame_size        = out_res.frame_size;
  assign frame_timestamp   = out_res.frame_timestamp;
  assign frame_index       = out_res.frame_index;
  assign frame_last        = out_res.frame_last;

endmodule

### rtl/ivfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfd_parser: input register and per-byte parse logic
// Registers each incoming byte, then classifies it against the parse state
// and updates the header fields, counters and mode.
// ----------------------------------------------------------------------------
module ivfd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  output logic            res_valid,
  input  logic            res_ready,
  output ivfd_pkg::res_t  res
);
  import ivfd_pkg::*;

  // Input stage
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       advance;

  // Parse state
  mode_t       parse_mode, parse_mode_next;
  logic [5:0]  field_byte_count, field_byte_count_next;
  logic [31:0] signature_shift, signature_shift_next;
  logic [31:0] version_and_length, version_and_length_next;
  logic [31:0] total_frames, total_frames_next;
  logic [31:0] size_shift, size_shift_next;
  logic [63:0] timestamp_shift, timestamp_shift_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [31:0] frames_done, frames_done_next;

  logic [31:0] frames_inc;
  logic        hdr_ok;

  assign advance   = stage_valid && res_ready;
  assign in_ready  = !stage_valid || res_ready;
  assign res_valid = stage_valid;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_byte <= data_byte;
    end
  end

  // State register, updated once per transfer out of the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode         <= MODE_FILE_HDR;
      field_byte_count   <= '0;
      signature_shift    <= '0;
      version_and_length <= '0;
      total_frames       <= '0;
      size_shift         <= '0;
      timestamp_shift    <= '0;
      payload_remaining  <= '0;
      frames_done        <= '0;
    end else if (advance) begin
      parse_mode         <= parse_mode_next;
      field_byte_count   <= field_byte_count_next;
      signature_shift    <= signature_shift_next;
      version_and_length <= version_and_length_next;
      total_frames       <= total_frames_next;
      size_shift         <= size_shift_next;
      timestamp_shift    <= timestamp_shift_next;
      payload_remaining  <= payload_remaining_next;
      frames_done        <= frames_done_next;
    end
  end

  assign frames_inc = frames_done + 32'd1;

  // Classification and next state
  always_comb begin
    parse_mode_next         = parse_mode;
    field_byte_count_next   = field_byte_count;
    signature_shift_next    = signature_shift;
    version_and_length_next = version_and_length;
    total_frames_next       = total_frames;
    size_shift_next         = size_shift;
    timestamp_shift_next    = timestamp_shift;
    payload_remaining_next  = payload_remaining;
    frames_done_next        = frames_done;
    hdr_ok                  = 1'b0;
    res                     = '0;

    unique case (parse_mode)
      MODE_FILE_HDR: begin
        res.byte_class = CLS_FILE_HDR;
        if (field_byte_count < SIG_END) begin
          signature_shift_next = {stage_byte, signature_shift[31:8]};
        end else if (field_byte_count < VL_END) begin
          version_and_length_next = {stage_byte, version_and_length[31:8]};
        end else if (field_byte_count >= COUNT_START && field_byte_count < COUNT_END) begin
          total_frames_next = {stage_byte, total_frames[31:8]};
        end
        if (field_byte_count >= FILE_HDR_LAST) begin
          hdr_ok = (signature_shift_next == IVF_MAGIC) &&
                   (version_and_length_next[15:0] == 16'd0) &&
                   (version_and_length_next[31:16] == FILE_HDR_LEN);
          res.header_accepted   = hdr_ok;
          field_byte_count_next = '0;
          if (!hdr_ok) begin
            parse_mode_next = MODE_REJECTED;
          end else if (frames_done >= total_frames_next) begin
            parse_mode_next = MODE_PAST_END;
          end else begin
            parse_mode_next = MODE_FRAME_HDR;
          end
        end else begin
          field_byte_count_next = field_byte_count + 6'd1;
        end
      end

      MODE_FRAME_HDR: begin
        res.byte_class = CLS_FRAME_HDR;
        if (field_byte_count < SIG_END) begin
          size_shift_next = {stage_byte, size_shift[31:8]};
        end else begin
          timestamp_shift_next = {stage_byte, timestamp_shift[63:8]};
        end
        if (field_byte_count >= FRAME_HDR_LAST) begin
          res.frame_header_done  = 1'b1;
          res.frame_size         = size_shift_next;
          res.frame_timestamp    = timestamp_shift_next;
          res.frame_index        = frames_done;
          field_byte_count_next  = '0;
          payload_remaining_next = size_shift_next;
          if (size_shift_next == 32'd0) begin
            // empty frame: header only
            frames_done_next = frames_inc;
            parse_mode_next  = (frames_inc >= total_frames) ? MODE_PAST_END
                                                            : MODE_FRAME_HDR;
          end else begin
            parse_mode_next = MODE_PAYLOAD;
          end
        end else begin
          field_byte_count_next = field_byte_count + 6'd1;
        end
      end

      MODE_PAYLOAD: begin
        res.byte_class      = CLS_PAYLOAD;
        res.payload_byte    = stage_byte;
        res.frame_size      = size_shift;
        res.frame_timestamp = timestamp_shift;
        res.frame_index     = frames_done;
        if (payload_remaining <= 32'd1) begin
          res.frame_last         = 1'b1;
          payload_remaining_next = '0;
          frames_done_next       = frames_inc;
          parse_mode_next        = (frames_inc >= total_frames) ? MODE_PAST_END
                                                                : MODE_FRAME_HDR;
        end else begin
          payload_remaining_next = payload_remaining - 32'd1;
        end
      end

      MODE_REJECTED: begin
        res.byte_class = CLS_REJECTED;
      end

      default: begin
        res.byte_class  = CLS_PAST_END;
        parse_mode_next = MODE_PAST_END;
      end
    endcase
  end

endmodule

### rtl/ivfd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfd_out_buf: two-entry result buffer
// Holds finished results so the parser keeps running while the consumer
// stalls, until both entries are full; accepts a result every cycle while not full.
// ----------------------------------------------------------------------------
module ivfd_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ivfd_pkg::res_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ivfd_pkg::res_t  rd_data
);
  import ivfd_pkg::*;

  res_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule
